// ===== design/utf8lcd_pkg.sv =====
// shared types, display codes and the character remap table
package utf8lcd_pkg;

    // display command codes
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_LINE1 = 8'h80;
    localparam logic [7:0] CMD_LINE2 = 8'hC0;

    // code substituted for a malformed sequence
    localparam logic [31:0] HOLLOW_SQUARE = 32'h00E2_96A1;
    localparam logic [31:0] CODE_NEWLINE  = 32'h0000_000A;

    // lead byte class limits
    localparam logic [7:0] LIMIT_ASCII = 8'h7F;
    localparam logic [7:0] LIMIT_CONT  = 8'hBF;
    localparam logic [7:0] LIMIT_TWO   = 8'hDF;
    localparam logic [7:0] LIMIT_THREE = 8'hEF;
    localparam logic [7:0] CONT_LOW    = 8'h80;

    // cursor positions
    localparam logic [5:0] POS_LINE2 = 6'd16;
    localparam logic [5:0] POS_FULL  = 6'd32;

    // glyph register indexes
    localparam logic [1:0] REG_BACKSLASH = 2'd0;
    localparam logic [1:0] REG_TILDE     = 2'd1;
    localparam logic [1:0] REG_MU        = 2'd2;
    localparam logic [1:0] REG_ROMAN11   = 2'd3;

    // cursor commands that precede a character
    localparam logic [1:0] PRE_NONE  = 2'd0;
    localparam logic [1:0] PRE_LINE2 = 2'd1;
    localparam logic [1:0] PRE_CLEAR = 2'd2;

    // one decoded character or cursor move, as queued for the back end
    typedef struct packed {
        logic [1:0] pre;
        logic       has_data;
        logic [7:0] data;
    } t_job;

    typedef logic [3:0][7:0] t_glyphs;

    // remap a packed code to a display character code
    function automatic logic [7:0] map_code(input logic [31:0] code, input t_glyphs glyph);
        logic [7:0] res;
        res = (code <= 32'(LIMIT_ASCII)) ? code[7:0] : code[7:0];
        case (code)
            32'h0000_005C: res = glyph[REG_BACKSLASH];
            32'h0000_007E: res = glyph[REG_TILDE];
            32'h0000_C2A5: res = 8'h5C;
            32'h0000_C2B0: res = 8'hDF;
            32'h0000_C2B5: res = 8'hE4;
            32'h0000_C39F: res = 8'hE2;
            32'h0000_C3A4: res = 8'hE1;
            32'h0000_C3B6: res = 8'hEF;
            32'h0000_C3B7: res = 8'hFD;
            32'h0000_C3BC: res = 8'hF5;
            32'h0000_CEA3: res = 8'hF6;
            32'h0000_CEA9: res = 8'hF4;
            32'h0000_CEB1: res = 8'hE0;
            32'h0000_CEB5: res = 8'hE3;
            32'h0000_CEBC: res = glyph[REG_MU];
            32'h0000_CF80: res = 8'hF7;
            32'h0000_CF81: res = 8'hE6;
            32'h0000_CF83: res = 8'hE5;
            32'h00E2_85BA: res = glyph[REG_ROMAN11];
            32'h00E2_8690: res = 8'h7F;
            32'h00E2_8692: res = 8'h7E;
            32'h00E2_889A: res = 8'hE8;
            32'h00E2_96A1: res = 8'hDB;
            32'h00E2_96AE: res = 8'hFF;
            default:       res = code[7:0];
        endcase
        return res;
    endfunction

endpackage

// ===== design/utf8lcd_front.sv =====
// front end: utf-8 assembly, cursor tracking, remap and glyph registers
module utf8lcd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [7:0]          i_text_byte,
    output logic                o_in_stall,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output logic                o_cfg_ready,
    input  logic                i_q_full,
    output logic                o_push,
    output utf8lcd_pkg::t_job   o_job
);
    import utf8lcd_pkg::*;

    logic [31:0] r_accum, n_accum;
    logic [1:0]  r_pending, n_pending;
    logic [5:0]  r_count, n_count;
    t_glyphs     r_glyph;
    logic        accept;
    logic        is_cont;
    logic        is_nl;
    logic [5:0]  cnt_moved;

    assign o_in_stall  = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_q_full;
    assign is_cont     = (i_text_byte >= CONT_LOW) && (i_text_byte <= LIMIT_CONT);

    // sequence assembly
    always_comb begin
        n_accum   = r_accum;
        n_pending = r_pending;
        if (r_pending == 2'd0) begin
            n_accum = {24'd0, i_text_byte};
            if (i_text_byte <= LIMIT_ASCII) begin
                n_pending = 2'd0;
            end else if (i_text_byte <= LIMIT_CONT) begin
                n_accum = HOLLOW_SQUARE;
            end else if (i_text_byte <= LIMIT_TWO) begin
                n_pending = 2'd1;
            end else if (i_text_byte <= LIMIT_THREE) begin
                n_pending = 2'd2;
            end else begin
                n_pending = 2'd3;
            end
        end else if (is_cont) begin
            n_accum   = {r_accum[23:0], i_text_byte};
            n_pending = r_pending - 2'd1;
        end else begin
            n_accum   = HOLLOW_SQUARE;
            n_pending = 2'd0;
        end
    end

    // cursor handling and job build for a complete character
    always_comb begin
        is_nl     = (n_accum == CODE_NEWLINE);
        cnt_moved = r_count;
        if (is_nl) begin
            cnt_moved = (r_count < POS_LINE2) ? POS_LINE2 : POS_FULL;
        end
        o_job.pre = PRE_NONE;
        n_count   = cnt_moved;
        if (cnt_moved == POS_LINE2) begin
            o_job.pre = PRE_LINE2;
        end else if (cnt_moved == POS_FULL) begin
            o_job.pre = PRE_CLEAR;
            n_count   = 6'd0;
        end
        o_job.has_data = !is_nl;
        o_job.data     = map_code(n_accum, r_glyph);
        if (!is_nl) begin
            n_count = n_count + 6'd1;
        end
    end

    assign o_push = accept && (n_pending == 2'd0);

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum   <= '0;
            r_pending <= '0;
            r_count   <= '0;
        end else if (accept) begin
            r_accum   <= n_accum;
            r_pending <= n_pending;
            if (n_pending == 2'd0) begin
                r_count <= n_count;
            end
        end
    end

    // glyph registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph[REG_BACKSLASH] <= 8'd0;
            r_glyph[REG_TILDE]     <= 8'd1;
            r_glyph[REG_MU]        <= 8'd2;
            r_glyph[REG_ROMAN11]   <= 8'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_glyph[i_cfg_index] <= i_cfg_data;
        end
    end

endmodule

// ===== design/utf8lcd_queue.sv =====
// job queue between front and back ends
module utf8lcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  utf8lcd_pkg::t_job   i_job,
    output logic                o_full,
    input  logic                i_pop,
    output utf8lcd_pkg::t_job   o_head,
    output logic                o_empty
);
    import utf8lcd_pkg::*;

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== design/utf8lcd_back.sv =====
// back end: expands each job into display writes, one per cycle unless stalled
module utf8lcd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utf8lcd_pkg::t_job   i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    output logic                o_is_data,
    output logic [7:0]          o_lcd_byte,
    output logic                o_last,
    input  logic                i_out_stall
);
    import utf8lcd_pkg::*;

    logic [1:0] r_step, n_step;
    logic       r_valid;
    logic       r_is_data;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] cmd_n;
    logic [1:0] total;
    logic       load;
    logic       step_last;
    logic       step_cmd;
    logic [7:0] step_byte;

    // result list of the head job
    always_comb begin
        case (i_head.pre)
            PRE_NONE:  cmd_n = 2'd0;
            PRE_LINE2: cmd_n = 2'd1;
            PRE_CLEAR: cmd_n = 2'd2;
            default:   cmd_n = 2'd0;
        endcase
        total     = cmd_n + {1'b0, i_head.has_data};
        step_last = (r_step == total - 2'd1);
        step_cmd  = (r_step < cmd_n);
        if (!step_cmd) begin
            step_byte = i_head.data;
        end else if (i_head.pre == PRE_LINE2) begin
            step_byte = CMD_LINE2;
        end else if (r_step == 2'd0) begin
            step_byte = CMD_CLEAR;
        end else begin
            step_byte = CMD_LINE1;
        end
    end

    assign load   = !i_empty && (!r_valid || !i_out_stall);
    assign o_pop  = load && step_last;
    assign n_step = load ? (step_last ? 2'd0 : r_step + 2'd1) : r_step;

    // step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_data <= !step_cmd;
            r_byte    <= step_byte;
            r_last    <= step_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_is_data   = r_is_data;
    assign o_lcd_byte  = r_byte;
    assign o_last      = r_last;

endmodule

// ===== design/utf8_char_lcd_writer_core.sv =====
// top level: utf-8 text to character display writes
//
// Input channel: one text byte per transaction (i_in_valid / o_in_stall).
// Output channel: one display write per transaction (o_out_valid /
// i_out_stall) with o_is_data (1 data, 0 command), o_lcd_byte and o_last,
// which marks the final write caused by one input byte. A byte that
// leaves a sequence unfinished causes no write at all.
// Configuration: i_cfg_valid / o_cfg_ready, index 0..3 selects the display
// codes used for backslash, tilde, mu and small roman eleven.
// Flow: a taken byte's job is registered in the queue, its first write in
// the output register. Each complete character gives one to three writes,
// issued one per cycle by the back-end sequencer unless the receiver
// stalls; the front end takes a byte every cycle while the queue has room.
// Reset clears the decoder, cursor position, queue and output register,
// and restores the glyph codes 0..3. While the receiver stalls, the
// current write holds, the queue fills and then o_in_stall rises.
module utf8_char_lcd_writer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_text_byte,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output logic       o_is_data,
    output logic [7:0] o_lcd_byte,
    output logic       o_last,
    input  logic       i_out_stall,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_cfg_ready
);
    import utf8lcd_pkg::*;

    t_job w_push_job;
    t_job w_head;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    // decode and classify
    utf8lcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_text_byte (i_text_byte),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // decoupling queue
    utf8lcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    // write sequencer
    utf8lcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_is_data   (o_is_data),
        .o_lcd_byte  (o_lcd_byte),
        .o_last      (o_last),
        .i_out_stall (i_out_stall)
    );

    // a job is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    // a job leaves the queue only with its final write
    a_pop_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_out_valid && o_last))
        else $error("job popped without final write");

    // a pending non-final write keeps its job in the queue
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !w_empty)
        else $error("job lost before its final write");

endmodule
